### rtl/pdsd_pkg.sv
// Shared types, constants and helper functions for the PCM decode and stereo downmix block.
package pdsd_pkg;

  localparam int MAX_CHANNELS = 32;
  localparam int CH_W = $clog2(MAX_CHANNELS);
  localparam int CNT_W = 6;
  localparam int WORD_W = 32;
  localparam int OUT_W = 24;
  localparam int SAMP_W = OUT_W + 1;
  localparam int ACC_W = 30;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] MAX_CH_COUNT = CNT_W'(MAX_CHANNELS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENCODING       = 3'd0,
    CFG_CONTAINER_BITS = 3'd1,
    CFG_VALID_BITS     = 3'd2,
    CFG_CHANNEL_COUNT  = 3'd3,
    CFG_SPEAKER_MASK   = 3'd4
  } cfg_idx_t;

  localparam logic ENC_PCM   = 1'b0;
  localparam logic ENC_FLOAT = 1'b1;

  localparam logic [5:0] CONT_8  = 6'd8;
  localparam logic [5:0] CONT_16 = 6'd16;
  localparam logic [5:0] CONT_24 = 6'd24;
  localparam logic [5:0] CONT_32 = 6'd32;

  localparam logic [15:0] GAIN_CENTER_Q16 = 16'd46341;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(8388608);

  // Speaker position bits.
  localparam logic [31:0] SPK_FL  = 32'h0000_0001;
  localparam logic [31:0] SPK_FR  = 32'h0000_0002;
  localparam logic [31:0] SPK_FC  = 32'h0000_0004;
  localparam logic [31:0] SPK_LFE = 32'h0000_0008;
  localparam logic [31:0] SPK_BL  = 32'h0000_0010;
  localparam logic [31:0] SPK_BR  = 32'h0000_0020;
  localparam logic [31:0] SPK_BC  = 32'h0000_0100;
  localparam logic [31:0] SPK_SL  = 32'h0000_0200;
  localparam logic [31:0] SPK_SR  = 32'h0000_0400;
  localparam logic [31:0] SPK_TFL = 32'h0000_1000;
  localparam logic [31:0] SPK_TFC = 32'h0000_2000;
  localparam logic [31:0] SPK_TFR = 32'h0000_4000;
  localparam logic [31:0] SPK_TBL = 32'h0000_8000;
  localparam logic [31:0] SPK_TBR = 32'h0002_0000;

  typedef enum logic [1:0] {
    GAIN_NONE,
    GAIN_UNIT,
    GAIN_CENTER,
    GAIN_HALF
  } gain_t;

  typedef struct packed {
    gain_t left;
    gain_t right;
  } route_t;

  // Gains for one speaker bit; an unknown or empty bit falls back on the channel index.
  function automatic route_t route_lookup(logic [31:0] spk, logic ch_is0, logic ch_is1);
    route_t r;
    r.left  = GAIN_NONE;
    r.right = GAIN_NONE;
    if (spk inside {SPK_FL, SPK_TFL, SPK_TBL}) begin
      r.left = GAIN_UNIT;
    end else if (spk inside {SPK_FR, SPK_TFR, SPK_TBR}) begin
      r.right = GAIN_UNIT;
    end else if (spk inside {SPK_FC, SPK_TFC, SPK_BC}) begin
      r.left  = GAIN_CENTER;
      r.right = GAIN_CENTER;
    end else if (spk == SPK_LFE) begin
      r.left  = GAIN_HALF;
      r.right = GAIN_HALF;
    end else if (spk inside {SPK_BL, SPK_SL}) begin
      r.left = GAIN_CENTER;
    end else if (spk inside {SPK_BR, SPK_SR}) begin
      r.right = GAIN_CENTER;
    end else if (ch_is0) begin
      r.left = GAIN_UNIT;
    end else if (ch_is1) begin
      r.right = GAIN_UNIT;
    end else begin
      r.left  = GAIN_HALF;
      r.right = GAIN_HALF;
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] saturate_out(logic signed [ACC_W-1:0] a);
    logic [OUT_W-1:0] r;
    if (a > SAT_HI) begin
      r = SAT_HI[OUT_W-1:0];
    end else if (a < SAT_LO) begin
      r = SAT_LO[OUT_W-1:0];
    end else begin
      r = a[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/pcm_decode_stereo_downmix.sv
// PCM / float32 sample decoder with multichannel to stereo downmix, top level.
// An accepted sample is decoded into the input register; the stereo pair of the frame
// it completes goes to the output register once free. One sample per cycle unless the
// output stalls; one pair per channel_count samples, clamped to the range 1 to 32.
// Reset: registers take their defaults (16-bit PCM, two channels, no speaker mask),
// the frame restarts and no result is pending.
module pcm_decode_stereo_downmix
  import pdsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [WORD_W-1:0]    s_axis_tdata,   // [31:0] sample_word
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*OUT_W-1:0]   m_axis_tdata,   // [23:0] left_out, [47:24] right_out
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  logic              encoding;
  logic [5:0]        container_bits;
  logic [5:0]        valid_bits;
  logic [CNT_W-1:0]  channel_count;
  logic [31:0]       speaker_mask;
  logic [31:0]       speaker_mask_next;
  logic              cfg_hit;

  logic [CH_W-1:0]   ch_cnt;
  logic [31:0]       remaining_mask;
  logic signed [ACC_W-1:0] left_acc;
  logic signed [ACC_W-1:0] right_acc;

  logic                     in_valid;
  logic signed [SAMP_W-1:0] in_sample;

  logic                   out_valid;
  logic [OUT_W-1:0]       left_out;
  logic [OUT_W-1:0]       right_out;

  // Decode of the incoming word.
  logic [31:0]        pcm_aligned;
  logic               pcm_ok;
  logic [5:0]         pcm_eff;
  logic [OUT_W-1:0]   pcm_keep;
  logic [OUT_W-1:0]   pcm_val;
  logic [OUT_W-1:0]   pcm8_val;
  logic [7:0]         flt_exp;
  logic [22:0]        flt_man;
  logic [7:0]         flt_shift;
  logic [OUT_W-1:0]   flt_mag;
  logic signed [SAMP_W-1:0] flt_val;
  logic signed [SAMP_W-1:0] dec_sample;

  always_comb begin
    pcm_ok = 1'b1;
    case (container_bits)
      CONT_16: pcm_aligned = {s_axis_tdata[15:0], 16'h0000};
      CONT_24: pcm_aligned = {s_axis_tdata[23:0], 8'h00};
      CONT_32: pcm_aligned = s_axis_tdata;
      default: begin
        pcm_aligned = '0;
        pcm_ok = 1'b0;
      end
    endcase
    pcm_eff = (valid_bits != 6'd0 && valid_bits <= container_bits) ? valid_bits
                                                                     : container_bits;
    for (int i = 0; i < OUT_W; i++) begin
      pcm_keep[i] = (6'(i) + pcm_eff) >= 6'd24;
    end
    pcm_val  = pcm_aligned[31:8] & pcm_keep;
    pcm8_val = {~s_axis_tdata[7], s_axis_tdata[6:0], 16'h0000};

    flt_exp   = s_axis_tdata[30:23];
    flt_man   = s_axis_tdata[22:0];
    flt_shift = 8'd127 - flt_exp;
    if (flt_exp == 8'hFF && flt_man != '0) begin
      flt_mag = '0;
    end else if (flt_exp >= 8'd127) begin
      flt_mag = 24'h80_0000;
    end else if (flt_exp == 8'd0 || flt_shift >= 8'd24) begin
      flt_mag = '0;
    end else begin
      flt_mag = {1'b1, flt_man} >> flt_shift[4:0];
    end
    flt_val = s_axis_tdata[31] ? -$signed({1'b0, flt_mag}) : $signed({1'b0, flt_mag});

    if (encoding == ENC_FLOAT) begin
      dec_sample = (container_bits == CONT_32) ? flt_val : '0;
    end else if (container_bits == CONT_8) begin
      dec_sample = SAMP_W'($signed(pcm8_val));
    end else if (pcm_ok) begin
      dec_sample = SAMP_W'($signed(pcm_val));
    end else begin
      dec_sample = '0;
    end
  end

  // Frame position and routing of the registered sample.
  logic [CNT_W-1:0]   n_eff;
  logic               mono;
  logic               last_ch;
  logic               produce;
  logic               advance;
  logic [31:0]        spk_bit;
  route_t             route;
  logic [OUT_W-1:0]   mag;
  logic [39:0]        prod_center;
  logic signed [SAMP_W-1:0] s_center;
  logic signed [SAMP_W-1:0] s_half;
  logic signed [SAMP_W-1:0] left_add;
  logic signed [SAMP_W-1:0] right_add;
  logic signed [ACC_W-1:0]  left_acc_next;
  logic signed [ACC_W-1:0]  right_acc_next;

  function automatic logic signed [SAMP_W-1:0] pick(gain_t g, logic signed [SAMP_W-1:0] s,
                                                    logic signed [SAMP_W-1:0] c,
                                                    logic signed [SAMP_W-1:0] h);
    logic signed [SAMP_W-1:0] r;
    case (g)
      GAIN_UNIT:   r = s;
      GAIN_CENTER: r = c;
      GAIN_HALF:   r = h;
      default:     r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    if (channel_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (channel_count > MAX_CH_COUNT) begin
      n_eff = MAX_CH_COUNT;
    end else begin
      n_eff = channel_count;
    end
    mono    = (n_eff == CNT_W'(1));
    last_ch = ({1'b0, ch_cnt} + CNT_W'(1)) >= n_eff;
    produce = mono || last_ch;
    advance = in_valid && (!produce || !out_valid || m_axis_tready);

    spk_bit = remaining_mask & (~remaining_mask + 32'd1);
    if (speaker_mask == '0) begin
      route.left  = (ch_cnt == CH_W'(0)) ? GAIN_UNIT : GAIN_NONE;
      route.right = (ch_cnt == CH_W'(1)) ? GAIN_UNIT : GAIN_NONE;
    end else begin
      route = route_lookup(spk_bit, ch_cnt == CH_W'(0), ch_cnt == CH_W'(1));
    end

    mag         = in_sample[SAMP_W-1] ? OUT_W'(-in_sample) : OUT_W'(in_sample);
    prod_center = mag * GAIN_CENTER_Q16;
    s_center = in_sample[SAMP_W-1] ? -$signed({1'b0, prod_center[39:16]})
                                   : $signed({1'b0, prod_center[39:16]});
    s_half   = in_sample[SAMP_W-1] ? -$signed({2'b00, mag[OUT_W-1:1]})
                                   : $signed({2'b00, mag[OUT_W-1:1]});
    left_add  = pick(route.left, in_sample, s_center, s_half);
    right_add = pick(route.right, in_sample, s_center, s_half);
    left_acc_next  = left_acc + ACC_W'(left_add);
    right_acc_next = right_acc + ACC_W'(right_add);
  end

  assign s_axis_tready = !in_valid || advance;

  // Configuration writes.
  always_comb begin
    cfg_hit = cfg_we && (cfg_index inside {CFG_ENCODING, CFG_CONTAINER_BITS, CFG_VALID_BITS,
                                           CFG_CHANNEL_COUNT, CFG_SPEAKER_MASK});
    speaker_mask_next = (cfg_we && cfg_index == CFG_SPEAKER_MASK) ? cfg_data : speaker_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      encoding       <= ENC_PCM;
      container_bits <= CONT_16;
      valid_bits     <= 6'd16;
      channel_count  <= CNT_W'(2);
      speaker_mask   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENCODING:       encoding       <= cfg_data[0];
        CFG_CONTAINER_BITS: container_bits <= cfg_data[5:0];
        CFG_VALID_BITS:     valid_bits     <= cfg_data[5:0];
        CFG_CHANNEL_COUNT:  channel_count  <= cfg_data[CNT_W-1:0];
        CFG_SPEAKER_MASK:   speaker_mask   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register holds the decoded sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample <= dec_sample;
    end
  end

  // Frame state and accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_cnt         <= '0;
      remaining_mask <= '0;
      left_acc       <= '0;
      right_acc      <= '0;
    end else if (cfg_hit || (advance && produce)) begin
      ch_cnt         <= '0;
      remaining_mask <= speaker_mask_next;
      left_acc       <= '0;
      right_acc      <= '0;
    end else if (advance) begin
      ch_cnt         <= ch_cnt + CH_W'(1);
      remaining_mask <= remaining_mask & ~spk_bit;
      left_acc       <= left_acc_next;
      right_acc      <= right_acc_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produce) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      if (mono) begin
        left_out  <= saturate_out(ACC_W'(in_sample));
        right_out <= saturate_out(ACC_W'(in_sample));
      end else begin
        left_out  <= saturate_out(left_acc_next);
        right_out <= saturate_out(right_acc_next);
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {right_out, left_out};

  // The channel position never reaches the frame length.
  a_ch_in_frame: assert property (@(posedge clk) disable iff (rst)
    {1'b0, ch_cnt} < n_eff)
    else $error("channel counter outside the frame");

  // Speaker bits still to be used come from the configured mask.
  a_mask_subset: assert property (@(posedge clk) disable iff (rst)
    (remaining_mask & ~speaker_mask) == '0)
    else $error("remaining mask holds a bit not in the speaker mask");

  // In mono the accumulators are never used.
  a_mono_idle_acc: assert property (@(posedge clk) disable iff (rst)
    mono |-> (left_acc == '0 && right_acc == '0))
    else $error("accumulator changed in mono mode");

  // A waiting sample is taken whenever the output register is free.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_valid) |-> s_axis_tready)
    else $error("input stalled with the output register empty");

  // A finished frame restarts the channel position.
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && produce && !cfg_hit) |=> ch_cnt == '0)
    else $error("channel counter not cleared after a frame");

endmodule
